@@ hdl/pvn_pkg.sv @@
// Package for the polygon vertex normal unit: widths, codes, structs and
// state encodings shared by the interfaces, the arithmetic units and the top.
// No dependencies.
package pvn_pkg;

  localparam int unsigned MaxVertices = 4096;
  localparam int unsigned CountW      = $clog2(MaxVertices + 1);
  localparam int unsigned IdxW        = 12;

  localparam int unsigned CoordW  = 24;             // Q12.12 coordinates
  localparam int unsigned NormW   = 16;             // Q2.14 normals
  localparam int unsigned EdgeW   = CoordW + 1;     // coordinate difference
  localparam int unsigned LenW    = EdgeW;          // edge length
  localparam int unsigned VecW    = 57;             // cross products and weighted sum
  localparam int unsigned MagW    = VecW;
  localparam int unsigned MagKeep = 30;             // magnitudes scaled below 2^30
  localparam int unsigned AccW    = 64;
  localparam int unsigned MulW    = 33;
  localparam int unsigned UnitW   = 32;             // Q2.30 unit components
  localparam int unsigned RootW   = 32;
  localparam int unsigned DivW    = 32;
  localparam int unsigned RemW    = RootW + 4;
  localparam int unsigned FracUnit = 30;
  localparam int unsigned FracOut  = 14;
  localparam int unsigned SqrtSteps = AccW / 2;
  localparam int unsigned DivSteps  = DivW;
  localparam int unsigned StepW   = $clog2(SqrtSteps + 1);

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    RegPnX = 2'd0,
    RegPnY = 2'd1,
    RegPnZ = 2'd2
  } cfg_reg_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [NormW-1:0]  norm_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  typedef struct packed {
    vertex_t a;
    vertex_t b;
    vertex_t c;
  } job_t;

  typedef struct packed {
    norm_t x;
    norm_t y;
    norm_t z;
  } normal_t;

  typedef struct packed {
    normal_t n;
    logic    ok;
  } nres_t;

  typedef enum logic [3:0] {
    CsIdle,
    CsEdgeMul,
    CsEdgeSqrt,
    CsCrossMul,
    CsUnLoad,
    CsUnShift,
    CsUnMul,
    CsUnSqrt,
    CsUnDiv,
    CsSumMul,
    CsDone
  } core_state_e;

  typedef enum logic [2:0] {
    SqIdle,
    SqStart,
    SqWait,
    SqEmit,
    SqCommit
  } seq_state_e;

endpackage

@@ hdl/pvn_vtx_if.sv @@
// Vertex input channel: valid/ready handshake with one vertex per item.
// Depends on pvn_pkg.
interface pvn_vtx_if import pvn_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t coord_x;
  coord_t coord_y;
  coord_t coord_z;
  logic   closes_polygon;

  modport source (output valid, coord_x, coord_y, coord_z, closes_polygon, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, closes_polygon, output ready);
endinterface

@@ hdl/pvn_nrm_if.sv @@
// Normal output channel: valid/ready handshake with one vertex normal per item.
// Depends on pvn_pkg.
interface pvn_nrm_if import pvn_pkg::*; ();
  logic            valid;
  logic            ready;
  norm_t           norm_x;
  norm_t           norm_y;
  norm_t           norm_z;
  logic [IdxW-1:0] vertex_index;
  logic            degenerate;
  logic            final_of_run;

  modport source (output valid, norm_x, norm_y, norm_z, vertex_index, degenerate,
                  final_of_run, input ready);
  modport sink   (input valid, norm_x, norm_y, norm_z, vertex_index, degenerate,
                  final_of_run, output ready);
endinterface

@@ hdl/pvn_sqrt.sv @@
// Iterative integer square root, two radicand bits per cycle (floor result).
// Depends on pvn_pkg.
module pvn_sqrt import pvn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AccW-1:0]  rad_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  logic [AccW-1:0]  rad_q, rad_d;
  logic [RemW-1:0]  rem_q, rem_d, rem_sh, trial;
  logic [RootW-1:0] root_q, root_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  assign rem_sh = {rem_q[RemW-3:0], rad_q[AccW-1 -: 2]};
  assign trial  = RemW'({root_q, 2'b01});

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = StepW'(SqrtSteps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[AccW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ hdl/pvn_div.sv @@
// Iterative restoring divider, one quotient bit per cycle. The caller keeps
// dividend < divisor * 2^32, so the quotient fits 32 bits. Depends on pvn_pkg.
module pvn_div import pvn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [AccW-1:0]    dividend_i,
  input  logic [RootW-2:0]   divisor_i,
  output logic               done_o,
  output logic [DivW-1:0]    quot_o
);

  logic [DivW-1:0]  rem_q, rem_d, dq_q, dq_d;
  logic [DivW:0]    trial, dsr;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  assign trial = {rem_q, dq_q[DivW-1]};
  assign dsr   = (DivW + 1)'(divisor_i);

  always_comb begin
    rem_d  = rem_q;
    dq_d   = dq_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i[AccW-1:DivW];
      dq_d   = dividend_i[DivW-1:0];
      cnt_d  = StepW'(DivSteps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= dsr) begin
        rem_d = DivW'(trial - dsr);
        dq_d  = {dq_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = trial[DivW-1:0];
        dq_d  = {dq_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

@@ hdl/pvn_core.sv @@
// Normal engine for one vertex: a sequencer around one shared multiplier,
// the square root unit and the divider. Depends on pvn_pkg, pvn_sqrt, pvn_div.
module pvn_core import pvn_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  job_t    job_i,
  input  normal_t pn_i,
  output logic    done_o,
  output nres_t   res_o
);

  core_state_e state_q, state_d;
  logic [2:0]  cnt_q, cnt_d, ai;
  logic [1:0]  di_q, di_d;
  logic        k_q, k_d, fin_q, fin_d, ok_q, ok_d, go_q, go_d;

  logic signed [EdgeW-1:0] e1_q [3], e1_d [3], e2_q [3], e2_d [3], e_sel [3];
  logic [LenW-1:0]         d_q [2], d_d [2];
  logic signed [VecW-1:0]  vec_q [3], vec_d [3];
  logic [MagW-1:0]         mag_q [3], mag_d [3];
  logic                    neg_q [3], neg_d [3];
  logic signed [UnitW-1:0] u1_q [3], u1_d [3], u2_q [3], u2_d [3];
  norm_t                   res_q [3], res_d [3];
  logic signed [AccW-1:0]  acc_q, acc_d, prod_q, prod_d, term;
  logic [RootW-2:0]        n_q, n_d;
  logic                    sub_q, sub_d;

  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [2*MulW-1:0] mul_p;

  logic               sq_start, sq_done, dv_start, dv_done, big;
  logic [RootW-1:0]   sq_root;
  logic [DivW-1:0]    dv_quot;
  logic [AccW-1:0]    dv_num;
  logic [MagKeep-1:0] mag_lo;
  norm_t              q_norm;
  logic signed [UnitW-1:0] q_unit;

  pvn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (acc_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  pvn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_num),
    .divisor_i  (n_q),
    .done_o     (dv_done),
    .quot_o     (dv_quot)
  );

  for (genvar g = 0; g < 3; g++) begin : g_esel
    assign e_sel[g] = k_q ? e2_q[g] : e1_q[g];
  end

  assign ai    = cnt_q - 3'd1;
  assign term  = sub_q ? -prod_q : prod_q;
  assign big   = |{mag_q[0][MagW-1:MagKeep], mag_q[1][MagW-1:MagKeep],
                   mag_q[2][MagW-1:MagKeep]};
  assign mag_lo = mag_q[di_q][MagKeep-1:0];
  assign dv_num = (fin_q ? (AccW'(mag_lo) << FracOut) : (AccW'(mag_lo) << FracUnit))
                  + AccW'(n_q[RootW-2:1]);
  assign q_norm = NormW'(dv_quot);
  assign q_unit = UnitW'(dv_quot);
  assign mul_p  = mul_a * mul_b;
  assign prod_d = mul_p[AccW-1:0];

  // operand select for the shared multiplier; the product is registered in prod_q
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sub_d = 1'b0;
    case (state_q)
      CsEdgeMul: begin
        case (cnt_q)
          3'd0: begin mul_a = MulW'(e_sel[0]); mul_b = MulW'(e_sel[0]); end
          3'd1: begin mul_a = MulW'(e_sel[1]); mul_b = MulW'(e_sel[1]); end
          3'd2: begin mul_a = MulW'(e_sel[2]); mul_b = MulW'(e_sel[2]); end
          default: ;
        endcase
      end
      CsCrossMul: begin
        case (cnt_q)
          3'd0: begin mul_a = MulW'(e_sel[1]); mul_b = MulW'(pn_i.z); end
          3'd1: begin mul_a = MulW'(e_sel[2]); mul_b = MulW'(pn_i.y); sub_d = 1'b1; end
          3'd2: begin mul_a = MulW'(e_sel[2]); mul_b = MulW'(pn_i.x); end
          3'd3: begin mul_a = MulW'(e_sel[0]); mul_b = MulW'(pn_i.z); sub_d = 1'b1; end
          3'd4: begin mul_a = MulW'(e_sel[0]); mul_b = MulW'(pn_i.y); end
          3'd5: begin mul_a = MulW'(e_sel[1]); mul_b = MulW'(pn_i.x); sub_d = 1'b1; end
          default: ;
        endcase
      end
      CsUnMul: begin
        case (cnt_q)
          3'd0: begin mul_a = MulW'(mag_q[0][MagKeep-1:0]); mul_b = MulW'(mag_q[0][MagKeep-1:0]); end
          3'd1: begin mul_a = MulW'(mag_q[1][MagKeep-1:0]); mul_b = MulW'(mag_q[1][MagKeep-1:0]); end
          3'd2: begin mul_a = MulW'(mag_q[2][MagKeep-1:0]); mul_b = MulW'(mag_q[2][MagKeep-1:0]); end
          default: ;
        endcase
      end
      CsSumMul: begin
        // weights swap: incoming direction times outgoing length and vice versa
        case (cnt_q)
          3'd0: begin mul_a = MulW'(d_q[1]); mul_b = MulW'(u1_q[0]); end
          3'd1: begin mul_a = MulW'(d_q[0]); mul_b = MulW'(u2_q[0]); end
          3'd2: begin mul_a = MulW'(d_q[1]); mul_b = MulW'(u1_q[1]); end
          3'd3: begin mul_a = MulW'(d_q[0]); mul_b = MulW'(u2_q[1]); end
          3'd4: begin mul_a = MulW'(d_q[1]); mul_b = MulW'(u1_q[2]); end
          3'd5: begin mul_a = MulW'(d_q[0]); mul_b = MulW'(u2_q[2]); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    di_d    = di_q;
    k_d     = k_q;
    fin_d   = fin_q;
    ok_d    = ok_q;
    go_d    = go_q;
    e1_d    = e1_q;
    e2_d    = e2_q;
    d_d     = d_q;
    vec_d   = vec_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    u1_d    = u1_q;
    u2_d    = u2_q;
    res_d   = res_q;
    acc_d   = acc_q;
    n_d     = n_q;
    sq_start = 1'b0;
    dv_start = 1'b0;
    done_o   = 1'b0;

    case (state_q)
      CsIdle: begin
        if (start_i) begin
          e1_d[0] = EdgeW'(job_i.b.x) - EdgeW'(job_i.a.x);
          e1_d[1] = EdgeW'(job_i.b.y) - EdgeW'(job_i.a.y);
          e1_d[2] = EdgeW'(job_i.b.z) - EdgeW'(job_i.a.z);
          e2_d[0] = EdgeW'(job_i.c.x) - EdgeW'(job_i.b.x);
          e2_d[1] = EdgeW'(job_i.c.y) - EdgeW'(job_i.b.y);
          e2_d[2] = EdgeW'(job_i.c.z) - EdgeW'(job_i.b.z);
          for (int i = 0; i < 3; i++) res_d[i] = '0;
          k_d     = 1'b0;
          fin_d   = 1'b0;
          ok_d    = 1'b1;
          go_d    = 1'b0;
          cnt_d   = '0;
          state_d = CsEdgeMul;
        end
      end
      CsEdgeMul, CsUnMul: begin
        if (cnt_q != 3'd0) acc_d = ((ai == 3'd0) ? '0 : acc_q) + term;
        if (cnt_q == 3'd3) begin
          cnt_d   = '0;
          go_d    = 1'b0;
          state_d = (state_q == CsEdgeMul) ? CsEdgeSqrt : CsUnSqrt;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      CsCrossMul, CsSumMul: begin
        if (cnt_q != 3'd0) begin
          if (!ai[0]) acc_d = term;
          else vec_d[ai[2:1]] = VecW'(acc_q + term);
        end
        if (cnt_q == 3'd6) begin
          cnt_d   = '0;
          fin_d   = (state_q == CsSumMul);
          state_d = CsUnLoad;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      CsEdgeSqrt: begin
        if (!go_q) begin
          sq_start = 1'b1;
          go_d     = 1'b1;
        end else if (sq_done) begin
          go_d = 1'b0;
          if (sq_root == '0) begin
            ok_d    = 1'b0;
            state_d = CsDone;
          end else begin
            d_d[k_q] = sq_root[LenW-1:0];
            cnt_d    = '0;
            state_d  = CsCrossMul;
          end
        end
      end
      CsUnLoad: begin
        for (int i = 0; i < 3; i++) begin
          neg_d[i] = vec_q[i][VecW-1];
          mag_d[i] = vec_q[i][VecW-1] ? MagW'(-vec_q[i]) : MagW'(vec_q[i]);
        end
        if (vec_q[0] == '0 && vec_q[1] == '0 && vec_q[2] == '0) begin
          ok_d    = 1'b0;
          state_d = CsDone;
        end else begin
          state_d = CsUnShift;
        end
      end
      CsUnShift: begin
        // bring the largest magnitude below 2^30, one bit a cycle
        if (big) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
        end else begin
          cnt_d   = '0;
          state_d = CsUnMul;
        end
      end
      CsUnSqrt: begin
        if (!go_q) begin
          sq_start = 1'b1;
          go_d     = 1'b1;
        end else if (sq_done) begin
          go_d = 1'b0;
          if (sq_root == '0) begin
            ok_d    = 1'b0;
            state_d = CsDone;
          end else begin
            n_d     = sq_root[RootW-2:0];
            di_d    = '0;
            state_d = CsUnDiv;
          end
        end
      end
      CsUnDiv: begin
        if (!go_q) begin
          dv_start = 1'b1;
          go_d     = 1'b1;
        end else if (dv_done) begin
          go_d = 1'b0;
          if (fin_q) res_d[di_q] = neg_q[di_q] ? -q_norm : q_norm;
          else if (!k_q) u1_d[di_q] = neg_q[di_q] ? -q_unit : q_unit;
          else u2_d[di_q] = neg_q[di_q] ? -q_unit : q_unit;
          if (di_q == 2'd2) begin
            cnt_d = '0;
            if (fin_q) begin
              state_d = CsDone;
            end else if (!k_q) begin
              k_d     = 1'b1;
              state_d = CsEdgeMul;
            end else begin
              state_d = CsSumMul;
            end
          end else begin
            di_d = di_q + 2'd1;
          end
        end
      end
      CsDone: begin
        done_o  = 1'b1;
        state_d = CsIdle;
      end
      default: state_d = CsIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CsIdle;
      cnt_q   <= '0;
      di_q    <= '0;
      k_q     <= 1'b0;
      fin_q   <= 1'b0;
      ok_q    <= 1'b0;
      go_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      di_q    <= di_d;
      k_q     <= k_d;
      fin_q   <= fin_d;
      ok_q    <= ok_d;
      go_q    <= go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e1_q   <= e1_d;
    e2_q   <= e2_d;
    d_q    <= d_d;
    vec_q  <= vec_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    u1_q   <= u1_d;
    u2_q   <= u2_d;
    res_q  <= res_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    sub_q  <= sub_d;
    n_q    <= n_d;
  end

  assign res_o.n.x = res_q[0];
  assign res_o.n.y = res_q[1];
  assign res_o.n.z = res_q[2];
  assign res_o.ok  = ok_q;

endmodule

@@ hdl/polygon_vertex_normal_unit.sv @@
// Top level of the polygon vertex normal unit: register port, polygon state,
// result sequencing and output register. Depends on pvn_pkg, pvn_vtx_if,
// pvn_nrm_if and pvn_core.
//
//   port      dir  handshake              carries
//   vtx_i     in   valid/ready            one vertex, closing flag
//   nrm_o     out  valid/ready            one normal, index, flags
//   apb       in   psel/penable/pready    plane normal x, y, z
//
// A full result uses the shared square root (five uses), the one-bit-a-cycle
// divider (nine uses) and the magnitude shifts. A degenerate result stops
// early. An item causes zero to three results.
// vtx_i.ready is high only when no item is in progress; a full output register
// holds the sequencer until nrm_o.ready. Reset needs no clearing pass.
module polygon_vertex_normal_unit import pvn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  pvn_vtx_if.sink          vtx_i,
  pvn_nrm_if.source        nrm_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  seq_state_e seq_q, seq_d;
  logic [1:0] jn_q, jn_d, njob;
  logic       cls_q;
  logic [CountW-1:0] count_q, idx_raw, idx_sat;
  vertex_t    p_q, first_q, second_q, older_q, recent_q;
  normal_t    pn_q;

  logic            out_valid_q, out_valid_d, load;
  normal_t         out_n_q;
  logic [IdxW-1:0] out_idx_q;
  logic            out_deg_q, out_fin_q;

  job_t  job;
  logic  job_fin, core_start, core_done, accept, commit, c_zero, c_one, wr_en;
  nres_t core_res;

  pvn_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_start),
    .job_i   (job),
    .pn_i    (pn_q),
    .done_o  (core_done),
    .res_o   (core_res)
  );

  // register port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q.x <= '0;
      pn_q.y <= '0;
      pn_q.z <= norm_t'(16384);
    end else if (wr_en) begin
      case (cfg_reg_e'(paddr[AddrW-1:2]))
        RegPnX:  pn_q.x <= pwdata[NormW-1:0];
        RegPnY:  pn_q.y <= pwdata[NormW-1:0];
        RegPnZ:  pn_q.z <= pwdata[NormW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[AddrW-1:2]))
      RegPnX:  prdata = DataW'(pn_q.x);
      RegPnY:  prdata = DataW'(pn_q.y);
      RegPnZ:  prdata = DataW'(pn_q.z);
      default: prdata = '0;
    endcase
  end

  // job list for the accepted vertex
  assign c_zero = (count_q == '0);
  assign c_one  = (count_q == CountW'(1));

  always_comb begin
    job     = '{a: older_q, b: recent_q, c: p_q};
    idx_raw = count_q - CountW'(1);
    job_fin = 1'b1;
    njob    = 2'd1;
    if (cls_q) begin
      if (c_zero) begin
        job     = '{a: p_q, b: p_q, c: p_q};
        idx_raw = '0;
      end else if (c_one) begin
        njob = 2'd2;
        if (jn_q == 2'd0) begin
          job     = '{a: first_q, b: p_q, c: first_q};
          idx_raw = CountW'(1);
          job_fin = 1'b0;
        end else begin
          job     = '{a: p_q, b: first_q, c: p_q};
          idx_raw = '0;
        end
      end else begin
        njob = 2'd3;
        case (jn_q)
          2'd0: job_fin = 1'b0;
          2'd1: begin
            job     = '{a: recent_q, b: p_q, c: first_q};
            idx_raw = count_q;
            job_fin = 1'b0;
          end
          default: begin
            job     = '{a: p_q, b: first_q, c: second_q};
            idx_raw = '0;
          end
        endcase
      end
    end else if (c_zero || c_one) begin
      njob = 2'd0;
    end
  end

  assign idx_sat = (idx_raw > CountW'(MaxVertices - 1)) ? CountW'(MaxVertices - 1) : idx_raw;

  // sequencer
  assign accept = vtx_i.valid && vtx_i.ready;
  assign vtx_i.ready = (seq_q == SqIdle);

  always_comb begin
    seq_d       = seq_q;
    jn_d        = jn_q;
    core_start  = 1'b0;
    load        = 1'b0;
    commit      = 1'b0;
    out_valid_d = out_valid_q && !nrm_o.ready;
    case (seq_q)
      SqIdle: begin
        if (accept) seq_d = SqStart;
      end
      SqStart: begin
        if (njob == 2'd0) begin
          seq_d = SqCommit;
        end else begin
          core_start = 1'b1;
          seq_d      = SqWait;
        end
      end
      SqWait: begin
        if (core_done) seq_d = SqEmit;
      end
      SqEmit: begin
        if (!out_valid_q || nrm_o.ready) begin
          load        = 1'b1;
          out_valid_d = 1'b1;
          if (jn_q == njob - 2'd1) begin
            jn_d  = '0;
            seq_d = SqCommit;
          end else begin
            jn_d  = jn_q + 2'd1;
            seq_d = SqStart;
          end
        end
      end
      SqCommit: begin
        commit = 1'b1;
        seq_d  = SqIdle;
      end
      default: seq_d = SqIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SqIdle;
      jn_q        <= '0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      cls_q       <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      jn_q        <= jn_d;
      out_valid_q <= out_valid_d;
      if (accept) cls_q <= vtx_i.closes_polygon;
      if (commit) begin
        if (cls_q) count_q <= '0;
        else if (count_q < CountW'(MaxVertices)) count_q <= count_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q.x <= vtx_i.coord_x;
      p_q.y <= vtx_i.coord_y;
      p_q.z <= vtx_i.coord_z;
    end
    if (commit && !cls_q) begin
      if (c_zero) first_q <= p_q;
      if (c_one) second_q <= p_q;
      older_q  <= recent_q;
      recent_q <= p_q;
    end
    if (load) begin
      out_n_q   <= core_res.ok ? core_res.n : '0;
      out_idx_q <= idx_sat[IdxW-1:0];
      out_deg_q <= !core_res.ok;
      out_fin_q <= job_fin;
    end
  end

  assign nrm_o.valid        = out_valid_q;
  assign nrm_o.norm_x       = out_n_q.x;
  assign nrm_o.norm_y       = out_n_q.y;
  assign nrm_o.norm_z       = out_n_q.z;
  assign nrm_o.vertex_index = out_idx_q;
  assign nrm_o.degenerate   = out_deg_q;
  assign nrm_o.final_of_run = out_fin_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> (seq_q == SqWait))
    else $error("core finished outside wait state");

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nrm_o.valid && nrm_o.degenerate) |->
      (nrm_o.norm_x == '0 && nrm_o.norm_y == '0 && nrm_o.norm_z == '0))
    else $error("degenerate result with nonzero normal");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxVertices))
    else $error("vertex count past saturation");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (seq_q == SqStart))
    else $error("accepted item did not start");

  a_commit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SqCommit) |=> (seq_q == SqIdle && jn_q == '0))
    else $error("commit did not return to idle");

endmodule

@@ tb/pvn_checker.sv @@
// Checker for the polygon vertex normal unit: watches the vertex, normal and
// register ports, predicts each normal and compares it. Depends on pvn_pkg,
// pvn_vtx_if and pvn_nrm_if.
`timescale 1ns / 100ps
module pvn_checker import pvn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  pvn_vtx_if               vtx,
  pvn_nrm_if               nrm,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o
);

  typedef longint vec_t [3];

  typedef struct {
    norm_t           nx;
    norm_t           ny;
    norm_t           nz;
    logic [IdxW-1:0] idx;
    logic            degen;
    logic            fin;
  } normal_rec_t;

  normal_rec_t want_q[$];

  longint pn_x, pn_y, pn_z;
  vec_t   vtx0, vtx1, vtx_old, vtx_new;
  int     poly_count;

  function automatic longint unsigned sqrt64(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit normalize(input vec_t v, output vec_t u, input int f);
    longint unsigned mag [3];
    longint unsigned m, sq, n, q;
    int s;
    m = 0;
    sq = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > m) m = mag[i];
      u[i] = 0;
    end
    if (m == 0) return 0;
    while ((m >> s) >= 64'd1 << 30) s++;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= s;
      sq += mag[i] * mag[i];
    end
    n = sqrt64(sq);
    if (n == 0) return 0;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << f) + n / 2) / n;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  // edge b-a crossed with the plane normal, plus its length
  function automatic void edge_cross(input vec_t a, input vec_t b, output vec_t c,
                                     output longint unsigned len);
    vec_t e;
    longint unsigned sq;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      e[i] = b[i] - a[i];
      sq += longint'(e[i] * e[i]);
    end
    len = sqrt64(sq);
    c[0] = e[1] * pn_z - e[2] * pn_y;
    c[1] = e[2] * pn_x - e[0] * pn_z;
    c[2] = e[0] * pn_y - e[1] * pn_x;
  endfunction

  function automatic normal_rec_t vertex_normal(input vec_t a, input vec_t b, input vec_t c,
                                                input int idx, input bit fin);
    vec_t c1, c2, u1, u2, v, r;
    longint unsigned d1, d2;
    bit ok;
    normal_rec_t rec;
    r = '{0, 0, 0};
    edge_cross(a, b, c1, d1);
    edge_cross(b, c, c2, d2);
    ok = (d1 != 0) && (d2 != 0);
    if (ok) ok = normalize(c1, u1, 30) && normalize(c2, u2, 30);
    if (ok) begin
      for (int i = 0; i < 3; i++) v[i] = longint'(d2) * u1[i] + longint'(d1) * u2[i];
      ok = normalize(v, r, 14);
    end
    if (!ok) r = '{0, 0, 0};
    if (idx > MaxVertices - 1) idx = MaxVertices - 1;
    rec.nx    = norm_t'(r[0]);
    rec.ny    = norm_t'(r[1]);
    rec.nz    = norm_t'(r[2]);
    rec.idx   = idx[IdxW-1:0];
    rec.degen = !ok;
    rec.fin   = fin;
    return rec;
  endfunction

  task automatic report(input string what, input longint got, input longint exp);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp);
    fail_count_o++;
  endtask

  task automatic add_want(input normal_rec_t rec);
    want_q.insert(want_q.size(), rec);
  endtask

  task automatic take_vertex(input vec_t p, input bit closes);
    if (closes) begin
      if (poly_count == 0) begin
        add_want(vertex_normal(p, p, p, 0, 1));
      end else if (poly_count == 1) begin
        add_want(vertex_normal(vtx0, p, vtx0, 1, 0));
        add_want(vertex_normal(p, vtx0, p, 0, 1));
      end else begin
        add_want(vertex_normal(vtx_old, vtx_new, p, poly_count - 1, 0));
        add_want(vertex_normal(vtx_new, p, vtx0, poly_count, 0));
        add_want(vertex_normal(p, vtx0, vtx1, 0, 1));
      end
      poly_count = 0;
    end else begin
      if (poly_count == 0) vtx0 = p;
      else if (poly_count == 1) vtx1 = p;
      else add_want(vertex_normal(vtx_old, vtx_new, p, poly_count - 1, 1));
      vtx_old = vtx_new;
      vtx_new = p;
      if (poly_count < MaxVertices) poly_count++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    checked_o    = 0;
    pn_x = 0;
    pn_y = 0;
    pn_z = 16384;
    vtx0 = '{0, 0, 0};
    vtx1 = '{0, 0, 0};
    vtx_old = '{0, 0, 0};
    vtx_new = '{0, 0, 0};
    poly_count = 0;
  end

  assign pending_o = want_q.size();

  always @(posedge clk_i) begin
    vec_t p;
    normal_rec_t w;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[AddrW-1:2]))
          RegPnX: pn_x = longint'(signed'(pwdata[15:0]));
          RegPnY: pn_y = longint'(signed'(pwdata[15:0]));
          RegPnZ: pn_z = longint'(signed'(pwdata[15:0]));
          default: ;
        endcase
      end
      if (vtx.valid && vtx.ready) begin
        p[0] = longint'(vtx.coord_x);
        p[1] = longint'(vtx.coord_y);
        p[2] = longint'(vtx.coord_z);
        take_vertex(p, vtx.closes_polygon);
      end
      if (nrm.valid && nrm.ready) begin
        if (want_q.size() == 0) begin
          report("item with nothing expected, vertex_index", nrm.vertex_index, -1);
        end else begin
          w = want_q.pop_front();
          checked_o++;
          if (nrm.norm_x !== w.nx) report("norm_x", nrm.norm_x, w.nx);
          if (nrm.norm_y !== w.ny) report("norm_y", nrm.norm_y, w.ny);
          if (nrm.norm_z !== w.nz) report("norm_z", nrm.norm_z, w.nz);
          if (nrm.vertex_index !== w.idx) report("vertex_index", nrm.vertex_index, w.idx);
          if (nrm.degenerate !== w.degen) report("degenerate", nrm.degenerate, w.degen);
          if (nrm.final_of_run !== w.fin) report("final_of_run", nrm.final_of_run, w.fin);
        end
      end
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the polygon vertex normal unit: clock, reset, vertex and
// register stimulus, receiver stalls, watchdog and verdict. Depends on
// pvn_pkg, the channel interfaces, pvn_checker and the unit itself.
`timescale 1ns / 100ps
module tb_top;
  import pvn_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int DrainWait = 2000;

  logic             clk_i;
  logic             rst_ni;
  logic             psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata, prdata;
  int               fail_count, pending, checked;
  int               tx_idle, rx_idle;
  int               vertices_sent, quiet_cycles;
  coord_t           last_x, last_y, last_z;

  pvn_vtx_if vtx();
  pvn_nrm_if nrm();

  polygon_vertex_normal_unit uut (
    .clk_i, .rst_ni, .vtx_i(vtx), .nrm_o(nrm),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pvn_checker u_checker (
    .clk_i, .rst_ni, .vtx, .nrm, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    nrm.ready <= ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((vtx.valid && vtx.ready) || (nrm.valid && nrm.ready) ||
        (psel && penable && pwrite)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("watchdog: no item moved for %0d cycles", IdleLimit);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_reg_e r, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(r) << 2;
    pwdata  <= {{16{val[15]}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z,
                             input logic closes);
    while ($urandom_range(99) < tx_idle) begin
      vtx.valid <= 1'b0;
      @(posedge clk_i);
    end
    vtx.valid          <= 1'b1;
    vtx.coord_x        <= x;
    vtx.coord_y        <= y;
    vtx.coord_z        <= z;
    vtx.closes_polygon <= closes;
    do @(posedge clk_i); while (!vtx.ready);
    last_x = x;
    last_y = y;
    last_z = z;
    vertices_sent++;
  endtask

  // drain results, then give a no-result item time to finish; the first edge
  // lets the checker book the last accepted item
  task automatic settle();
    vtx.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_normal(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
    settle();
    write_reg(RegPnX, x);
    write_reg(RegPnY, y);
    write_reg(RegPnZ, z);
  endtask

  function automatic coord_t pick_coord(input coord_t prev);
    case ($urandom_range(9))
      0: return coord_t'($urandom());
      1: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      2: return prev;
      3: return prev + coord_t'($urandom_range(15)) - 24'sd8;
      default: return coord_t'($urandom_range(32767)) - 24'sd16384;
    endcase
  endfunction

  task automatic random_polygons(input int n_items);
    int len, k;
    coord_t x, y, z;
    k = 0;
    while (k < n_items) begin
      case ($urandom_range(9))
        0: len = 1;
        1: len = 2;
        2: len = $urandom_range(9, 20);
        default: len = $urandom_range(3, 8);
      endcase
      for (int i = 0; i < len; i++) begin
        x = pick_coord(last_x);
        y = pick_coord(last_y);
        // sometimes draw z at random over its full range
        z = ($urandom_range(7) == 0) ? coord_t'($urandom()) : pick_coord(last_z);
        send_vertex(x, y, z, i == len - 1);
      end
      k += len;
      if ($urandom_range(19) == 0) begin
        vtx.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    nrm.ready = 1'b0;
    vtx.valid = 1'b0;
    vtx.coord_x = '0;
    vtx.coord_y = '0;
    vtx.coord_z = '0;
    vtx.closes_polygon = 1'b0;
    last_x = '0;
    last_y = '0;
    last_z = '0;
    tx_idle = 25;
    rx_idle = 76;
    vertices_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: lone closing vertex, two-vertex polygon, square, extremes
    send_vertex(24'sd100, -24'sd50, 24'sd7, 1'b1);
    send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_vertex(24'sd4096, 24'sd0, 24'sd0, 1'b1);
    send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_vertex(24'sd4096, 24'sd0, 24'sd0, 1'b0);
    send_vertex(24'sd4096, 24'sd4096, 24'sd0, 1'b0);
    send_vertex(24'sd0, 24'sd4096, 24'sd0, 1'b1);
    send_vertex(24'sh800000, 24'sh800000, 24'sh800000, 1'b0);
    send_vertex(24'sh7fffff, 24'sh800000, 24'sh7fffff, 1'b0);
    send_vertex(24'sh7fffff, 24'sh7fffff, 24'sh800000, 1'b0);
    send_vertex(24'sh800000, 24'sh7fffff, 24'sh7fffff, 1'b1);
    // repeated vertex gives a zero edge; a pure z step lies along the normal
    send_vertex(24'sd10, 24'sd10, 24'sd0, 1'b0);
    send_vertex(24'sd10, 24'sd10, 24'sd0, 1'b0);
    send_vertex(24'sd10, 24'sd10, 24'sd9000, 1'b0);
    send_vertex(24'sd500, 24'sd20, 24'sd0, 1'b1);
    // back and forth on a line: directions cancel
    send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_vertex(24'sd3000, 24'sd0, 24'sd0, 1'b0);
    send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_vertex(24'sd3000, 24'sd0, 24'sd0, 1'b1);

    random_polygons(63);

    set_normal(16'sd16384, 16'sd0, 16'sd0);
    random_polygons(63);

    tx_idle = 76;
    rx_idle = 25;
    set_normal(-16'sd16384, 16'sd16384, -16'sd16384);
    random_polygons(63);
    set_normal(16'sd0, 16'sd0, 16'sd0);
    send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_vertex(24'sd4096, 24'sd0, 24'sd0, 1'b0);
    send_vertex(24'sd0, 24'sd4096, 24'sd0, 1'b1);
    set_normal(16'($urandom()), 16'($urandom()), 16'($urandom()));
    random_polygons(63);

    tx_idle = 0;
    rx_idle = 0;
    set_normal(16'sd9459, -16'sd9459, 16'sd9459);
    random_polygons(63);
    set_normal(16'($urandom_range(32768)) - 16'sd16384,
               16'($urandom_range(32768)) - 16'sd16384,
               16'($urandom_range(32768)) - 16'sd16384);
    random_polygons(63);

    vtx.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    $display("sent %0d vertices under 7 plane normals and 3 stall patterns", vertices_sent);
    $display("checked %0d normals, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
